// ----- hdl/iplpr_pkg.sv -----
// Shared types, codes and helpers of the IPv4 longest prefix router unit.
`default_nettype none

package iplpr_pkg;

   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 6;
   localparam int PORT_W   = 4;
   localparam int TTL_W    = 8;
   localparam int STATUS_W = 2;

   localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

   localparam logic ACT_ADD   = 1'b0;
   localparam logic ACT_ROUTE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED = 2'd0,
      ST_FULL  = 2'd1,
      ST_FWD   = 2'd2,
      ST_DROP  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DONE
   } state_type;

   // Record that walks down the cell chain. For an add, key is the masked
   // prefix and has_hop, hop and port carry the new route. For a lookup, key
   // is the destination and has_hop, hop and port hold the best route so far.
   typedef struct packed {
      logic              active;
      logic              action;
      logic [ADDR_W-1:0] key;
      logic [LEN_W-1:0]  len;
      logic [TTL_W-1:0]  ttl;
      logic              hit;
      logic [LEN_W-1:0]  best_len;
      logic              has_hop;
      logic [ADDR_W-1:0] hop;
      logic [PORT_W-1:0] port;
      logic              dup;
      logic              free;
   } carry_type;

   // Broadcast write of one route entry.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] prefix;
      logic [LEN_W-1:0]  len;
      logic              has_hop;
      logic [ADDR_W-1:0] hop;
      logic [PORT_W-1:0] port;
   } write_type;

   // Mask of the top len bits of an address; len must not exceed 32.
   function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
      logic [ADDR_W-1:0] ones;
      ones = '1;
      return ~(ones >> len);
   endfunction

endpackage

`default_nettype wire

// ----- hdl/ipv4_longest_prefix_router_unit.sv -----
// Top level of the IPv4 longest prefix router: request staging, cell chain and result stage.
// A request passes the staging register, the register of each table cell, the tail register,
// where the outcome is settled, and the result register on its way to rsp_valid.
// The search record walks the cell chain one cell per cycle and a single item is in flight at a
// time: a new request is taken only after the result of the last one is loaded.
// Reset is synchronous and active high; it empties the route table and drops any item in flight.
`default_nettype none

module ipv4_longest_prefix_router_unit
   import iplpr_pkg::*;
#(
   parameter int ROUTES = 32,
   parameter int PORTS  = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_action,
   input  wire logic [ADDR_W-1:0] req_route_prefix,
   input  wire logic [LEN_W-1:0]  req_prefix_len,
   input  wire logic              req_has_next_hop,
   input  wire logic [ADDR_W-1:0] req_gateway_addr,
   input  wire logic [PORT_W-1:0] req_port_index,
   input  wire logic [ADDR_W-1:0] req_dest_addr,
   input  wire logic [TTL_W-1:0]  req_ttl_in,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [PORT_W-1:0]      rsp_out_port,
   output logic [ADDR_W-1:0]      rsp_out_next_hop,
   output logic [TTL_W-1:0]       rsp_ttl_out
);

   localparam int IDX_W = (ROUTES > 1) ? $clog2(ROUTES) : 1;
   // Interface numbers are compared in nine bits so that PORTS values up to 511 fit.
   localparam logic [8:0] PORT_LIMIT = 9'(PORTS);

   // The head register stages an accepted request as a search record.
   carry_type         head_ff;
   carry_type         head_in;

   // Chain links: entry 0 is the head, entry i+1 is the output of cell i.
   carry_type         chain     [ROUTES+1];
   logic [IDX_W-1:0]  chain_dup [ROUTES+1];
   logic [IDX_W-1:0]  chain_free[ROUTES+1];
   logic [ROUTES-1:0] valid_vec;
   logic [ROUTES:0]   active_vec;

   // The tail register holds the finished record until the result stage is free.
   carry_type         tail_ff;
   logic [IDX_W-1:0]  tail_dup_ff;
   logic [IDX_W-1:0]  tail_free_ff;

   state_type         state_ff;
   state_type         state_in;
   logic              tail_load;
   logic              rsp_load;

   write_type         wr;
   logic [IDX_W-1:0]  wr_idx;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   status_type        rsp_status_ff;
   status_type        rsp_status_in;
   logic [PORT_W-1:0] rsp_port_ff;
   logic [PORT_W-1:0] rsp_port_in;
   logic [ADDR_W-1:0] rsp_hop_ff;
   logic [ADDR_W-1:0] rsp_hop_in;
   logic [TTL_W-1:0]  rsp_ttl_ff;
   logic [TTL_W-1:0]  rsp_ttl_in;

   logic              req_xfer;
   logic              rsp_free;
   logic [LEN_W-1:0]  sat_len;
   logic              port_ok;

   // A new request is taken only when no item is in flight.
   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Build the search record. Prefix lengths above 32 saturate, and an add
   // keeps only the top bits of its prefix so that equal routes compare equal.
   always_comb begin
      sat_len = (req_prefix_len > MAX_LEN) ? MAX_LEN : req_prefix_len;
      head_in          = '0;
      head_in.active   = req_xfer;
      head_in.action   = req_action;
      head_in.len      = sat_len;
      head_in.ttl      = req_ttl_in;
      head_in.has_hop  = req_has_next_hop;
      head_in.hop      = req_gateway_addr;
      head_in.port     = req_port_index;
      if (req_action == ACT_ADD) begin
         head_in.key = req_route_prefix & len_mask(sat_len);
      end else begin
         head_in.key = req_dest_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.active <= 1'b0;
      end else begin
         head_ff <= head_in;
      end
   end

   assign chain[0]      = head_ff;
   assign chain_dup[0]  = '0;
   assign chain_free[0] = '0;

   for (genvar i = 0; i < ROUTES; i++) begin : g_cell
      iplpr_cell #(
         .IDX_W   (IDX_W),
         .CELL_ID (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .prev_carry    (chain[i]),
         .prev_dup_idx  (chain_dup[i]),
         .prev_free_idx (chain_free[i]),
         .next_carry    (chain[i+1]),
         .next_dup_idx  (chain_dup[i+1]),
         .next_free_idx (chain_free[i+1]),
         .wr            (wr),
         .wr_idx        (wr_idx),
         .entry_valid   (valid_vec[i])
      );
   end

   for (genvar j = 0; j <= ROUTES; j++) begin : g_active
      assign active_vec[j] = chain[j].active;
   end

   always_ff @(posedge clock) begin
      if (tail_load) begin
         tail_ff      <= chain[ROUTES];
         tail_dup_ff  <= chain_dup[ROUTES];
         tail_free_ff <= chain_free[ROUTES];
      end
   end

   // Settle the outcome from the finished record. An add reuses a route with
   // the same prefix and length, else takes the lowest free cell, else
   // reports a full table. A lookup forwards only with a match, a usable
   // interface and a TTL above one.
   always_comb begin
      port_ok       = ({5'd0, tail_ff.port} < PORT_LIMIT);
      wr            = '0;
      wr.prefix     = tail_ff.key;
      wr.len        = tail_ff.len;
      wr.has_hop    = tail_ff.has_hop;
      wr.hop        = tail_ff.hop;
      wr.port       = tail_ff.port;
      wr_idx        = tail_ff.dup ? tail_dup_ff : tail_free_ff;
      rsp_status_in = ST_DROP;
      rsp_port_in   = '0;
      rsp_hop_in    = '0;
      rsp_ttl_in    = '0;
      if (tail_ff.action == ACT_ADD) begin
         if (tail_ff.dup || tail_ff.free) begin
            rsp_status_in = ST_ADDED;
            wr.en         = rsp_load;
         end else begin
            rsp_status_in = ST_FULL;
         end
      end else if (tail_ff.hit && (tail_ff.ttl > 8'd1) && port_ok) begin
         rsp_status_in = ST_FWD;
         rsp_port_in   = tail_ff.port;
         rsp_hop_in    = tail_ff.has_hop ? tail_ff.hop : tail_ff.key;
         rsp_ttl_in    = tail_ff.ttl - 8'd1;
      end
   end

   always_comb begin
      state_in  = state_ff;
      tail_load = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (chain[ROUTES].active) begin
               tail_load = 1'b1;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The result register frees the chain while a finished result waits for its transfer.
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_port_ff   <= rsp_port_in;
         rsp_hop_ff    <= rsp_hop_in;
         rsp_ttl_ff    <= rsp_ttl_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_port     = rsp_port_ff;
   assign rsp_out_next_hop = rsp_hop_ff;
   assign rsp_ttl_out      = rsp_ttl_ff;

   // At most one search record is ever on the chain.
   a_single_record: assert property (@(posedge clock) disable iff (reset)
      $onehot0(active_vec))
      else $error("more than one search record on the cell chain");

   // Once a request is taken, the next cycle takes none.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("request taken while another item is in flight");

   // A full table report means every cell holds a route.
   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_FULL)) |-> (&valid_vec))
      else $error("table full reported with a free cell");

   // A forwarded datagram always leaves with a nonzero TTL.
   a_fwd_ttl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_FWD)) |-> (rsp_ttl_ff != 8'd0))
      else $error("forwarded datagram with zero TTL");

endmodule

`default_nettype wire

// ----- hdl/iplpr_cell.sv -----
// One route table cell: holds one entry and updates the passing search record.
`default_nettype none

module iplpr_cell
   import iplpr_pkg::*;
#(
   parameter int IDX_W   = 5,
   parameter int CELL_ID = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire carry_type        prev_carry,
   input  wire logic [IDX_W-1:0] prev_dup_idx,
   input  wire logic [IDX_W-1:0] prev_free_idx,
   output carry_type             next_carry,
   output logic      [IDX_W-1:0] next_dup_idx,
   output logic      [IDX_W-1:0] next_free_idx,
   input  wire write_type        wr,
   input  wire logic [IDX_W-1:0] wr_idx,
   output logic                  entry_valid
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

   logic              valid_ff;
   logic [ADDR_W-1:0] prefix_ff;
   logic [LEN_W-1:0]  len_ff;
   logic              has_hop_ff;
   logic [ADDR_W-1:0] hop_ff;
   logic [PORT_W-1:0] port_ff;

   carry_type         carry_ff;
   carry_type         carry_in;
   logic [IDX_W-1:0]  dup_idx_ff;
   logic [IDX_W-1:0]  dup_idx_in;
   logic [IDX_W-1:0]  free_idx_ff;
   logic [IDX_W-1:0]  free_idx_in;

   logic              hit_here;
   logic              same_here;
   logic              wr_here;

   assign wr_here = wr.en && (wr_idx == MY_IDX);

   always_comb begin
      hit_here  = valid_ff && ((prev_carry.key & len_mask(len_ff)) == prefix_ff);
      same_here = valid_ff && (len_ff == prev_carry.len) && (prefix_ff == prev_carry.key);
      carry_in    = prev_carry;
      dup_idx_in  = prev_dup_idx;
      free_idx_in = prev_free_idx;
      if (prev_carry.active) begin
         if (prev_carry.action == ACT_ROUTE) begin
            // Strictly longer wins, so the lowest index wins a tie.
            if (hit_here && (!prev_carry.hit || (len_ff > prev_carry.best_len))) begin
               carry_in.hit      = 1'b1;
               carry_in.best_len = len_ff;
               carry_in.has_hop  = has_hop_ff;
               carry_in.hop      = hop_ff;
               carry_in.port     = port_ff;
            end
         end else begin
            if (same_here && !prev_carry.dup) begin
               carry_in.dup = 1'b1;
               dup_idx_in   = MY_IDX;
            end
            if (!valid_ff && !prev_carry.free) begin
               carry_in.free = 1'b1;
               free_idx_in   = MY_IDX;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff.active <= 1'b0;
      end else begin
         carry_ff <= carry_in;
      end
      dup_idx_ff  <= dup_idx_in;
      free_idx_ff <= free_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_here) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_here) begin
         prefix_ff  <= wr.prefix;
         len_ff     <= wr.len;
         has_hop_ff <= wr.has_hop;
         hop_ff     <= wr.hop;
         port_ff    <= wr.port;
      end
   end

   assign next_carry    = carry_ff;
   assign next_dup_idx  = dup_idx_ff;
   assign next_free_idx = free_idx_ff;
   assign entry_valid   = valid_ff;

endmodule

`default_nettype wire
